@@ hw/rtl/rna_pkg.sv @@
// Package for the rational arithmetic unit: operation codes, status codes,
// width constants and the controller/datapath command and status structs.
// No dependencies.
package rna_pkg;

  localparam int NumWidthDef = 32;
  localparam int IoW         = 32;
  localparam int MagW        = 66;
  localparam int CntW        = 7;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_NEG = 4'd4;
  localparam logic [3:0] OP_INV = 4'd5;
  localparam logic [3:0] OP_ABS = 4'd6;
  localparam logic [3:0] OP_RED = 4'd7;
  localparam logic [3:0] OP_CMP = 4'd8;
  localparam logic [3:0] OP_INT = 4'd9;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // Datapath commands from the controller.
  typedef struct packed {
    logic load;     // capture operands, decode
    logic mul;      // register cross products
    logic combine;  // form signed numerator and denominator
    logic gcd_load; // seed Euclid with numerator and denominator
    logic gcd_step; // one Euclid remainder bit step
    logic gcd_init; // start a remainder
    logic gcd_swap; // finish one remainder
    logic div_init; // start dividing by gcd
    logic div_step; // one quotient bit for both parts
    logic finish;   // form result
  } rna_cmd_t;

  typedef struct packed {
    logic early;    // result known from decode or compare
    logic gcd_done; // divisor is zero
    logic is_int;   // integral part path
  } rna_stat_t;

endpackage

@@ hw/rtl/rna_if.sv @@
// Valid/ready channel interface carrying an item payload.
// Depends on nothing; the payload type is a parameter.
interface rna_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/rna_datapath.sv @@
// Datapath of the rational unit: operand split, cross products, shared
// restoring divider used for Euclid remainders, gcd division and result.
// Depends on rna_pkg.
module rna_datapath #(
  parameter int NUM_WIDTH = rna_pkg::NumWidthDef
) (
  input  logic                   clk,
  input  logic [3:0]             operation,
  input  logic [rna_pkg::IoW-1:0] a_num,
  input  logic [rna_pkg::IoW-1:0] a_den,
  input  logic [rna_pkg::IoW-1:0] b_num,
  input  logic [rna_pkg::IoW-1:0] b_den,
  input  rna_pkg::rna_cmd_t      cmd,
  output rna_pkg::rna_stat_t     stat,
  output logic [rna_pkg::IoW-1:0] result_num,
  output logic [rna_pkg::IoW-1:0] result_den,
  output logic [1:0]             order,
  output logic [1:0]             status
);
  localparam int W  = NUM_WIDTH;
  localparam int MW = rna_pkg::MagW;
  localparam int OW = rna_pkg::IoW;

  logic [3:0]   op;
  logic         an, bn, neg;
  logic [W-1:0] am, ad, bm, bd;
  logic [2*W-1:0] p0, p1, p2;
  logic [MW-1:0]  mag, den, ga, gb, rem, quo, qd, rd;
  logic           early;
  logic [1:0]     e_status, e_order;
  logic [OW-1:0]  e_num, e_den;

  logic [W-1:0] an_raw, bn_raw;
  assign an_raw = a_num[W-1:0];
  assign bn_raw = b_num[W-1:0];

  // Split and early decode of error, compare-free and unknown cases.
  logic         an_c, bn_c;
  logic [W-1:0] am_c, bm_c, ad_c, bd_c;
  logic         binop;
  logic         ld_unknown, ld_zero;
  assign an_c  = an_raw[W-1];
  assign bn_c  = bn_raw[W-1];
  assign am_c  = an_c ? (~an_raw + 1'b1) : an_raw;
  assign bm_c  = bn_c ? (~bn_raw + 1'b1) : bn_raw;
  assign ad_c  = a_den[W-1:0];
  assign bd_c  = b_den[W-1:0];
  assign binop = (operation <= rna_pkg::OP_DIV) || (operation == rna_pkg::OP_CMP);
  assign ld_unknown = operation > rna_pkg::OP_INT;
  assign ld_zero    = ad_c == '0 || (binop && bd_c == '0) ||
                      (operation == rna_pkg::OP_DIV && bm_c == '0) ||
                      (operation == rna_pkg::OP_INV && am_c == '0);

  // Cross-product operand selection
  logic [W-1:0] m0a, m0b, m1a, m1b, m2a, m2b;
  always_comb begin
    m0a = am; m0b = bd; m1a = bm; m1b = ad; m2a = ad; m2b = bd;
    case (op)
      rna_pkg::OP_MUL: begin m0a = am; m0b = bm; end
      rna_pkg::OP_DIV: begin m2a = ad; m2b = bm; end
      default: ;
    endcase
  end

  // Signed combine of the two cross products
  logic [MW-1:0] x0, x1, sum;
  logic          s0, s1, ssum;
  always_comb begin
    x0 = {{(MW-2*W){1'b0}}, p0};
    x1 = {{(MW-2*W){1'b0}}, p1};
    s0 = an;
    s1 = (op == rna_pkg::OP_ADD) ? bn : ~bn;
    if (s0 == s1) begin
      sum = x0 + x1; ssum = s0;
    end else if (x0 >= x1) begin
      sum = x0 - x1; ssum = s0;
    end else begin
      sum = x1 - x0; ssum = s1;
    end
  end

  // Restoring divider step shared by Euclid and the gcd division
  logic [MW-1:0] rsh, rsub;
  logic          rge;
  assign rsh  = {rem[MW-2:0], quo[MW-1]};
  assign rge  = rsh >= qd;
  assign rsub = rsh - qd;

  logic [MW-1:0] rsh2, rsub2;
  logic          rge2;
  assign rsh2  = {rd[MW-2:0], den[MW-1]};
  assign rge2  = rsh2 >= ga;
  assign rsub2 = rsh2 - ga;

  logic [MW-1:0] maxpos;
  assign maxpos = (MW'(1) << (W - 1)) - MW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= operation;
      an <= an_c; bn <= bn_c; am <= am_c; bm <= bm_c; ad <= ad_c; bd <= bd_c;
      early    <= ld_unknown || ld_zero;
      e_order  <= rna_pkg::ORD_LT;
      e_status <= (!ld_unknown && ld_zero) ? rna_pkg::ST_ZERO : rna_pkg::ST_OK;
      e_num    <= '0;
      e_den    <= (!ld_unknown && ld_zero) ? '0 : OW'(1);
    end
    if (cmd.mul) begin
      p0 <= m0a * m0b;
      p1 <= m1a * m1b;
      p2 <= m2a * m2b;
    end
    if (cmd.combine) begin
      case (op)
        rna_pkg::OP_ADD, rna_pkg::OP_SUB: begin
          mag <= sum; neg <= ssum; den <= {{(MW-2*W){1'b0}}, p2};
        end
        rna_pkg::OP_MUL, rna_pkg::OP_DIV: begin
          mag <= {{(MW-2*W){1'b0}}, p0}; neg <= an ^ bn;
          den <= {{(MW-2*W){1'b0}}, p2};
        end
        rna_pkg::OP_NEG: begin mag <= MW'(am); neg <= ~an; den <= MW'(ad); end
        rna_pkg::OP_INV: begin mag <= MW'(ad); neg <= an; den <= MW'(am); end
        rna_pkg::OP_ABS: begin mag <= MW'(am); neg <= 1'b0; den <= MW'(ad); end
        rna_pkg::OP_CMP: begin
          early   <= 1'b1;
          e_order <= (sum == '0) ? rna_pkg::ORD_EQ :
                     (ssum ? rna_pkg::ORD_LT : rna_pkg::ORD_GT);
        end
        default: begin mag <= MW'(am); neg <= an; den <= MW'(ad); end
      endcase
      // Integral part: divide am by ad directly, ga holds the divisor
      if (op == rna_pkg::OP_INT) begin
        ga <= MW'(ad); gb <= '0;
      end
    end
    // Euclid: ga, gb start as mag, den
    if (cmd.gcd_load) begin
      ga <= mag; gb <= den;
    end
    if (cmd.gcd_init) begin
      qd <= gb; quo <= ga; rem <= '0;
    end
    if (cmd.gcd_step) begin
      rem <= rge ? rsub : rsh;
      quo <= {quo[MW-2:0], 1'b0};
    end
    if (cmd.gcd_swap) begin
      ga <= gb; gb <= rem;
    end
    // Divide mag (in quo) and den (in den) by ga, one bit each per cycle
    if (cmd.div_init) begin
      if (op == rna_pkg::OP_INT) ga <= MW'(ad);
      quo <= (op == rna_pkg::OP_INT) ? MW'(am) : mag;
      rem <= '0; rd <= '0;
      qd  <= (op == rna_pkg::OP_INT) ? MW'(ad) : ga;
    end
    if (cmd.div_step) begin
      rem <= rge ? rsub : rsh;
      quo <= {quo[MW-2:0], rge};
      rd  <= rge2 ? rsub2 : rsh2;
      den <= {den[MW-2:0], rge2};
    end
    if (cmd.finish) begin
      if (early) begin
        result_num <= e_num; result_den <= e_den;
        order <= e_order; status <= e_status;
      end else if (op == rna_pkg::OP_INT) begin
        result_num <= OW'(an ? (~quo + 1'b1) : quo);
        result_den <= OW'(1);
        order <= rna_pkg::ORD_LT; status <= rna_pkg::ST_OK;
      end else if (quo == '0) begin
        result_num <= '0; result_den <= OW'(1);
        order <= rna_pkg::ORD_LT; status <= rna_pkg::ST_OK;
      end else if (quo > (neg ? maxpos + MW'(1) : maxpos) ||
                   (den >> W) != '0) begin
        result_num <= '0; result_den <= '0;
        order <= rna_pkg::ORD_LT; status <= rna_pkg::ST_OVF;
      end else begin
        result_num <= OW'(neg ? (~quo + 1'b1) : quo);
        result_den <= OW'(den);
        order <= rna_pkg::ORD_LT; status <= rna_pkg::ST_OK;
      end
    end
  end

  assign stat.early    = early;
  assign stat.gcd_done = (gb == '0);
  assign stat.is_int   = (op == rna_pkg::OP_INT);
endmodule

@@ hw/rtl/rna_ctrl.sv @@
// Controller state machine of the rational unit: sequences decode,
// products, Euclid remainders, the gcd division and result handoff.
// Depends on rna_pkg.
module rna_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rna_pkg::rna_stat_t stat,
  output rna_pkg::rna_cmd_t  cmd
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_COMB  = 4'd2;
  localparam logic [3:0] S_GCHK  = 4'd3;
  localparam logic [3:0] S_GDIV  = 4'd4;
  localparam logic [3:0] S_GSWP  = 4'd5;
  localparam logic [3:0] S_DINI  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_GINI  = 4'd9;

  localparam int Steps = rna_pkg::MagW;

  logic [3:0] state, state_next;
  logic [rna_pkg::CntW-1:0] cnt, cnt_next;
  logic out_full, out_full_next;

  // Accept when idle; a waiting result sits in its own register
  assign in_ready  = (state == S_IDLE);
  assign out_valid = out_full;

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    out_full_next = out_full && !out_ready;
    cmd           = '0;
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.load = 1'b1; state_next = S_MUL;
      end
      S_MUL: begin
        if (stat.early) state_next = S_FIN;
        else begin cmd.mul = 1'b1; state_next = S_COMB; end
      end
      S_COMB: begin
        cmd.combine = 1'b1;
        state_next  = stat.is_int ? S_DINI : S_GINI;
      end
      S_GINI: begin
        cmd.gcd_load = 1'b1; cnt_next = '0;
        state_next = S_GCHK;
      end
      S_GCHK: begin
        if (stat.early) state_next = S_FIN;
        else if (stat.gcd_done) state_next = S_DINI;
        else begin cmd.gcd_init = 1'b1; cnt_next = '0; state_next = S_GDIV; end
      end
      S_GDIV: begin
        cmd.gcd_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == rna_pkg::CntW'(Steps - 1)) state_next = S_GSWP;
      end
      S_GSWP: begin
        cmd.gcd_swap = 1'b1; state_next = S_GCHK;
      end
      S_DINI: begin
        cmd.div_init = 1'b1; cnt_next = '0; state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == rna_pkg::CntW'(Steps - 1)) state_next = S_FIN;
      end
      S_FIN: if (!out_full || out_ready) begin
        cmd.finish = 1'b1; out_full_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; cnt <= '0; out_full <= 1'b0;
    end else begin
      state <= state_next; cnt <= cnt_next; out_full <= out_full_next;
    end
  end

`ifndef ASSERT_OFF
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_full || out_ready)) else $error("result overwritten");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_MUL)) else $error("load did not start work");
  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_full) else $error("finished result not shown");
`endif
endmodule

@@ hw/rtl/rational_number_alu_core.sv @@
// Channel   | Dir | Payload
// in_ch     | in  | operation, a_num, a_den, b_num, b_den
// out_ch    | out | result_num, result_den, order, status
// One item at a time: errors and unknown codes skip the products, compares
// end after the signed combine, the integral part after one direct division;
// fractions run Euclid remainders on the 66-bit restoring divider, up to ~95
// of them, then the last gcd check, the gcd division and the result.
// The result waits in an output register while the next item may be taken;
// reset rst is synchronous.
// Top level of the rational unit; depends on rna_pkg, rna_if, rna_ctrl,
// rna_datapath.
module rational_number_alu_core #(
  parameter int NUM_WIDTH = rna_pkg::NumWidthDef
) (
  input logic clk,
  input logic rst,
  rna_if.sink   in_ch,
  rna_if.source out_ch
);
  rna_pkg::rna_cmd_t  cmd;
  rna_pkg::rna_stat_t stat;

  rna_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  rna_datapath #(.NUM_WIDTH(NUM_WIDTH)) u_dp (
    .clk(clk),
    .operation(in_ch.data.operation),
    .a_num(in_ch.data.a_num), .a_den(in_ch.data.a_den),
    .b_num(in_ch.data.b_num), .b_den(in_ch.data.b_den),
    .cmd(cmd), .stat(stat),
    .result_num(out_ch.data.result_num), .result_den(out_ch.data.result_den),
    .order(out_ch.data.order), .status(out_ch.data.status)
  );
endmodule

@@ dv/rna_result_checker.sv @@
// Result checker for the rational arithmetic unit: predicts each result from
// the accepted input items and compares it field by field with the output.
// Depends on rna_pkg for operation, status and order codes.
module rna_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  operation,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] result_num,
  input  logic [31:0] result_den,
  input  logic [1:0]  order,
  input  logic [1:0]  status,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic [1:0]  ord;
    logic [1:0]  st;
  } frac_res_t;

  localparam logic [63:0] MASK32 = 64'hFFFF_FFFF;

  frac_res_t expected_fracs[$];

  function automatic frac_res_t make_res(logic [63:0] num, logic [63:0] den,
                                         logic [1:0] ord, logic [1:0] st);
    frac_res_t r;
    r.num = num[31:0];
    r.den = den[31:0];
    r.ord = ord;
    r.st  = st;
    return r;
  endfunction

  function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Reduce by gcd, then range check against signed/unsigned 32 bits
  function automatic frac_res_t reduce_frac(logic neg, logic [63:0] mag, logic [63:0] den);
    logic [63:0] g;
    logic [63:0] lim;
    g = gcd_of(mag, den);
    if (g != 0) begin
      mag = mag / g;
      den = den / g;
    end
    if (mag == 0) begin
      neg = 1'b0;
      den = 1;
    end
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (mag > lim || den > MASK32)
      return make_res(0, 0, rna_pkg::ORD_LT, rna_pkg::ST_OVF);
    return make_res(neg ? -mag : mag, den, rna_pkg::ORD_LT, rna_pkg::ST_OK);
  endfunction

  // Signed sum of sign-magnitude values
  function automatic logic [63:0] sm_sum(logic sa, logic [63:0] ma, logic sb,
                                         logic [63:0] mb, output logic sr);
    if (sa == sb) begin
      sr = sa;
      return ma + mb;
    end
    if (ma >= mb) begin
      sr = sa;
      return ma - mb;
    end
    sr = sb;
    return mb - ma;
  endfunction

  function automatic frac_res_t predict_frac(logic [3:0] op, logic [31:0] an_raw,
                                             logic [31:0] ad_raw, logic [31:0] bn_raw,
                                             logic [31:0] bd_raw);
    logic        an, bn, sr;
    logic [63:0] am, bm, ad, bd, m;
    an = an_raw[31];
    bn = bn_raw[31];
    am = {32'd0, an ? -an_raw : an_raw};
    bm = {32'd0, bn ? -bn_raw : bn_raw};
    ad = {32'd0, ad_raw};
    bd = {32'd0, bd_raw};
    if (op > rna_pkg::OP_INT) return make_res(0, 1, rna_pkg::ORD_LT, rna_pkg::ST_OK);
    if (ad == 0 || ((op <= rna_pkg::OP_DIV || op == rna_pkg::OP_CMP) && bd == 0))
      return make_res(0, 0, rna_pkg::ORD_LT, rna_pkg::ST_ZERO);
    case (op)
      rna_pkg::OP_ADD, rna_pkg::OP_SUB: begin
        m = sm_sum(an, am * bd, (op == rna_pkg::OP_SUB) ? !bn : bn, bm * ad, sr);
        return reduce_frac(sr, m, ad * bd);
      end
      rna_pkg::OP_MUL: return reduce_frac(an != bn, am * bm, ad * bd);
      rna_pkg::OP_DIV: begin
        if (bm == 0) return make_res(0, 0, rna_pkg::ORD_LT, rna_pkg::ST_ZERO);
        return reduce_frac(an != bn, am * bd, ad * bm);
      end
      rna_pkg::OP_NEG: return reduce_frac(!an, am, ad);
      rna_pkg::OP_INV: begin
        if (am == 0) return make_res(0, 0, rna_pkg::ORD_LT, rna_pkg::ST_ZERO);
        return reduce_frac(an, ad, am);
      end
      rna_pkg::OP_ABS: return reduce_frac(1'b0, am, ad);
      rna_pkg::OP_RED: return reduce_frac(an, am, ad);
      rna_pkg::OP_CMP: begin
        m = sm_sum(an, am * bd, !bn, bm * ad, sr);
        return make_res(0, 1, (m == 0) ? rna_pkg::ORD_EQ :
                        (sr ? rna_pkg::ORD_LT : rna_pkg::ORD_GT), rna_pkg::ST_OK);
      end
      default: begin
        m = am / ad;
        return make_res(an ? -m : m, 1, rna_pkg::ORD_LT, rna_pkg::ST_OK);
      end
    endcase
  endfunction

  // Watch both channels at the clock edge
  always @(posedge clk) begin
    frac_res_t exp_r;
    if (rst) begin
      errors  <= 0;
      pending = 0;
    end else begin
      if (in_valid && in_ready)
        expected_fracs.push_back(predict_frac(operation, a_num, a_den, b_num, b_den));
      if (out_valid && out_ready) begin
        if (expected_fracs.size() == 0) begin
          if (errors < 10)
            $display("unexpected result num=%h den=%h order=%0d status=%0d",
                     result_num, result_den, order, status);
          errors <= errors + 1;
        end else begin
          exp_r = expected_fracs.pop_front();
          if (exp_r.num !== result_num || exp_r.den !== result_den ||
              exp_r.ord !== order || exp_r.st !== status) begin
            if (errors < 10)
              $display({"mismatch: expected num=%h den=%h order=%0d status=%0d,",
                        " got num=%h den=%h order=%0d status=%0d"},
                       exp_r.num, exp_r.den, exp_r.ord, exp_r.st,
                       result_num, result_den, order, status);
            errors <= errors + 1;
          end
        end
      end
      pending = expected_fracs.size();
    end
  end

endmodule

@@ dv/rational_number_alu_core_tb.sv @@
// Testbench top for rational_number_alu_core: clock, reset, directed and
// random operand items, output stalls and the verdict.
// Depends on rna_pkg, rna_if, the core and rna_result_checker.
module rational_number_alu_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]  operation;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } operand_item_t;

  typedef struct packed {
    logic [31:0] result_num;
    logic [31:0] result_den;
    logic [1:0]  order;
    logic [1:0]  status;
  } frac_item_t;

  localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [31:0] MINN = 32'h8000_0000;
  localparam logic [31:0] UMAX = 32'hFFFF_FFFF;
  localparam int RANDOM_ITEMS = 1530;
  localparam int LONG_HOLD    = 3000;

  logic clk;
  logic rst;
  logic in_fire;
  logic out_fire;
  int   errors;
  int   pending;
  int   burst_left;
  int   results_seen;

  rna_if #(.payload_t(operand_item_t)) in_ch ();
  rna_if #(.payload_t(frac_item_t))    out_ch ();

  rational_number_alu_core DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rna_result_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .operation  (in_ch.data.operation),
    .a_num      (in_ch.data.a_num),
    .a_den      (in_ch.data.a_den),
    .b_num      (in_ch.data.b_num),
    .b_den      (in_ch.data.b_den),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .result_num (out_ch.data.result_num),
    .result_den (out_ch.data.result_den),
    .order      (out_ch.data.order),
    .status     (out_ch.data.status),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Handshake flags, read at the falling edge
  always @(posedge clk) begin
    in_fire  <= in_ch.valid & in_ch.ready;
    out_fire <= out_ch.valid & out_ch.ready;
  end

  initial begin
    #200_000_000;
    $display("[rational_number_alu_core] ERROR");
    $finish;
  end

  // Offer one item; idle between bursts
  task automatic send_item(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.data  = '{op, an, ad, bn, bd};
    do @(negedge clk); while (!in_fire);
    in_ch.valid = 1'b0;
  endtask

  function automatic logic [31:0] rand_num(int span);
    case (span)
      0: return $urandom_range(0, 8190) - 4095;
      1: return $urandom_range(0, 131070) - 65535;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_den(int span);
    if ($urandom_range(0, 24) == 0) return 32'd0;
    case (span)
      0: return $urandom_range(1, 4095);
      1: return $urandom_range(1, 65535);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: randomly changing ready pattern, with one long hold-off
  initial begin
    int mode;
    int cyc;
    logic held;
    out_ch.ready = 1'b0;
    results_seen = 0;
    held = 1'b0;
    cyc  = 0;
    mode = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (out_fire) results_seen++;
      if (!held && results_seen >= 300) begin
        held = 1'b1;
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        if (out_fire) results_seen++;
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = $urandom_range(0, 1);
        2: out_ch.ready = ($urandom_range(0, 3) == 0);
        default: out_ch.ready = (cyc % 8) < 5;
      endcase
      cyc++;
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    int sel;
    int span;
    logic [3:0] op;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    burst_left  = 0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, every operation and each special case
    send_item(rna_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_item(rna_pkg::OP_ADD, MAXP, 32'd1, MAXP, 32'd1);
    send_item(rna_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_item(rna_pkg::OP_SUB, MINN, 32'd1, 32'd1, 32'd1);
    send_item(rna_pkg::OP_MUL, MAXP, UMAX, MINN, UMAX);
    send_item(rna_pkg::OP_MUL, 32'd3, 32'd4, 32'd5, 32'd0);
    send_item(rna_pkg::OP_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
    send_item(rna_pkg::OP_DIV, -32'sd6, 32'd7, 32'd3, 32'd14);
    send_item(rna_pkg::OP_NEG, MINN, 32'd1, 32'd0, 32'd0);
    send_item(rna_pkg::OP_NEG, 32'd5, 32'd10, UMAX, UMAX);
    send_item(rna_pkg::OP_INV, 32'd0, 32'd3, 32'd0, 32'd0);
    send_item(rna_pkg::OP_INV, -32'sd3, UMAX, 32'd0, 32'd0);
    send_item(rna_pkg::OP_ABS, MINN, 32'd2, 32'd0, 32'd0);
    send_item(rna_pkg::OP_ABS, MINN, 32'd1, 32'd0, 32'd0);
    send_item(rna_pkg::OP_RED, -32'sd12, UMAX, 32'd0, 32'd0);
    send_item(rna_pkg::OP_RED, 32'd0, 32'd7, 32'd0, 32'd0);
    send_item(rna_pkg::OP_RED, 32'd9, 32'd0, 32'd0, 32'd0);
    send_item(rna_pkg::OP_CMP, 32'd1, 32'd3, 32'd2, 32'd6);
    send_item(rna_pkg::OP_CMP, MINN, 32'd1, MAXP, UMAX);
    send_item(rna_pkg::OP_CMP, 32'd5, 32'd1, -32'sd5, 32'd1);
    send_item(rna_pkg::OP_CMP, 32'd5, 32'd1, 32'd5, 32'd0);
    send_item(rna_pkg::OP_INT, -32'sd7, 32'd2, 32'd0, 32'd0);
    send_item(rna_pkg::OP_INT, MAXP, 32'd1, 32'd0, 32'd0);
    send_item(4'd10, 32'd1, 32'd1, 32'd1, 32'd1);
    send_item(4'd15, MINN, 32'd0, MINN, 32'd0);

    // Random: mostly small operands, some medium and full width
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      sel  = $urandom_range(0, 9);
      span = (sel < 6) ? 0 : (sel < 8) ? 1 : 2;
      op   = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
      send_item(op, rand_num(span), rand_den(span), rand_num(span), rand_den(span));
    end

    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("[rational_number_alu_core] OK");
    end else begin
      $display("[rational_number_alu_core] ERROR");
    end
    $finish;
  end

endmodule
